@@ rtl/core/worst_fit_allocator_assert.svh @@
// Assertion macros shared by the worst-fit allocator checkers.
// Depends on a clk and rst_n visible where the macros are used.
`ifndef WORST_FIT_ALLOCATOR_ASSERT_SVH
`define WORST_FIT_ALLOCATOR_ASSERT_SVH
// Checked property, disabled while reset is asserted.
`define WFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that also holds during reset.
`define WFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ rtl/core/wfa_pkg.sv @@
// Package for the worst-fit allocator: action codes, controller states,
// cell control struct and default sizes. No dependencies.
package wfa_pkg;
  localparam int unsigned MEM_CELLS_DEF   = 128;
  localparam int unsigned MAX_REGIONS_DEF = 64;
  localparam int unsigned REQ_W  = 8;
  localparam int unsigned IDX_W  = 7;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned RIX_W  = 6;
  localparam int unsigned SIZE_W = 8;
  localparam int unsigned RCNT_W = 7;

  typedef enum logic [2:0] {
    ACT_CLEAR     = 3'd0,
    ACT_APPEND    = 3'd1,
    ACT_ALLOC     = 3'd2,
    ACT_RD_CELL   = 3'd3,
    ACT_RD_REGION = 3'd4
  } wfa_act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_RDCELL,
    ST_DONE
  } wfa_state_t;

  typedef struct packed {
    logic scan_alloc;
    logic wr_first;
    logic wr_last;
  } wfa_ctl_t;
endpackage

@@ rtl/core/wfa_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module wfa_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/wfa_cell.sv @@
// One region record of the allocator chain: holds start and end of a region
// and passes the search token on to its neighbor. Depends on wfa_pkg.
module wfa_cell import wfa_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned MEM_CELLS = MEM_CELLS_DEF,
  parameter int unsigned MAX_REGIONS = MAX_REGIONS_DEF,
  localparam int unsigned AW = $clog2(MEM_CELLS),
  localparam int unsigned LW = $clog2(MEM_CELLS + 1),
  localparam int unsigned RW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  wfa_ctl_t      ctl,
  input  logic [RW-1:0] wr_idx,
  input  logic [LW-1:0] wr_first,
  input  logic [AW-1:0] wr_last,
  input  logic [CW-1:0] used,
  input  logic [RW-1:0] query_idx,
  input  logic          tok_vld_i,
  input  logic          tok_hit_i,
  input  logic [LW-1:0] tok_sz_i,
  input  logic [RW-1:0] tok_idx_i,
  input  logic [LW-1:0] tok_first_i,
  output logic          tok_vld_o,
  output logic          tok_hit_o,
  output logic [LW-1:0] tok_sz_o,
  output logic [RW-1:0] tok_idx_o,
  output logic [LW-1:0] tok_first_o
);
  logic [LW-1:0] first_r;
  logic [AW-1:0] last_r;
  logic [LW-1:0] end_w;
  logic [LW-1:0] my_sz;
  logic          active;
  logic          take;
  logic          sel;

  assign sel    = (wr_idx == RW'(IDX));
  assign end_w  = LW'(last_r) + LW'(1);
  assign my_sz  = (end_w >= first_r) ? (end_w - first_r) : '0;
  assign active = (CW'(IDX) < used);
  assign take   = tok_vld_i && active &&
                  (ctl.scan_alloc ? (!tok_hit_i || (my_sz > tok_sz_i))
                                  : (query_idx == RW'(IDX)));

  always_ff @(posedge clk) begin
    if (ctl.wr_first && sel) begin
      first_r <= wr_first;
    end
    if (ctl.wr_last && sel) begin
      last_r <= wr_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_o <= 1'b0;
    end else begin
      tok_vld_o <= tok_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    tok_hit_o   <= take | tok_hit_i;
    tok_sz_o    <= take ? my_sz : tok_sz_i;
    tok_idx_o   <= take ? RW'(IDX) : tok_idx_i;
    tok_first_o <= take ? first_r : tok_first_i;
  end
endmodule

@@ rtl/core/worst_fit_allocator.sv @@
// Worst-fit allocator: builds a cell map, keeps free regions in a chain of
// region cells and serves allocate and read requests.
// Depends on wfa_pkg, wfa_cell and wfa_ram.
//
// The input stream carries one action per transfer: in_tuser holds the
// action code, in_tdata the cell bit, request size and index. Every action
// yields exactly one result transfer on the output stream.
// Clear, append and unknown actions go straight to the result. A cell read
// goes through the registered map memory. A region read waits for the
// search token to walk the region chain.
// An allocate also waits for the token and then marks each granted cell,
// since the map memory marks one cell per cycle.
// One action is in work at a time; in_tready is high only while idle.
// A finished result waits in the output register while out_tready is low.
// The next action may be taken meanwhile; its own result is held back until
// the output register has handed its transfer over.
// Reset empties the map and the region list; the cell map and region
// records need no clearing, since only written entries are ever read.
module worst_fit_allocator import wfa_pkg::*; #(
  parameter int unsigned MEM_CELLS   = MEM_CELLS_DEF,
  parameter int unsigned MAX_REGIONS = MAX_REGIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cell_bit [0], request_size [8:1], index [15:9]
  input  logic [15:0] in_tdata,
  // action [2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // ok [0], position [7:1], region_index [13:8], size [21:14],
  // cell_value [22], region_count [29:23]
  output logic [31:0] out_tdata
);
  localparam int unsigned AW = $clog2(MEM_CELLS);
  localparam int unsigned LW = $clog2(MEM_CELLS + 1);
  localparam int unsigned RW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned CMPW = (LW > REQ_W) ? LW : REQ_W;
  localparam int unsigned IXW  = (LW > IDX_W) ? ((LW > CW) ? LW : CW)
                                               : ((IDX_W > CW) ? IDX_W : CW);

  wfa_state_t state_r, state_nxt;

  logic [LW-1:0]    map_len_r, map_len_nxt;
  logic [CW-1:0]    used_r, used_nxt;
  logic             prev_free_r, prev_free_nxt;
  logic             mode_alloc_r, mode_alloc_nxt;
  logic             inject_r, inject_nxt;
  logic [REQ_W-1:0] req_r, req_nxt;
  logic [RW-1:0]    query_r, query_nxt;
  logic [AW-1:0]    mark_addr_r, mark_addr_nxt;
  logic [REQ_W-1:0] mark_left_r, mark_left_nxt;
  logic             ok_r, ok_nxt;
  logic [LW-1:0]    pos_r, pos_nxt;
  logic [RW-1:0]    rix_r, rix_nxt;
  logic [LW-1:0]    sz_r, sz_nxt;
  logic             cval_r, cval_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [31:0]      out_data_r, out_data_nxt;

  logic             in_bit;
  logic [REQ_W-1:0] in_req;
  logic [IDX_W-1:0] in_idx;
  logic             accept;
  logic             cell_in_range;
  logic             reg_in_range;
  logic             grant;
  logic             out_free;

  wfa_ctl_t         ctl;
  logic [RW-1:0]    wr_idx;
  logic [LW-1:0]    wr_first;
  logic [AW-1:0]    wr_last;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic             ram_wdata;
  logic             ram_rdata;

  logic             tok_vld   [MAX_REGIONS+1];
  logic             tok_hit   [MAX_REGIONS+1];
  logic [LW-1:0]    tok_sz    [MAX_REGIONS+1];
  logic [RW-1:0]    tok_idx   [MAX_REGIONS+1];
  logic [LW-1:0]    tok_first [MAX_REGIONS+1];

  assign in_bit  = in_tdata[0];
  assign in_req  = in_tdata[8:1];
  assign in_idx  = in_tdata[15:9];
  assign accept  = in_tvalid && in_tready;
  assign out_free = !out_vld_r || out_tready;

  assign cell_in_range = (IXW'(in_idx) < IXW'(map_len_r));
  assign reg_in_range  = (IXW'(in_idx) < IXW'(used_r));
  assign grant = (CMPW'(tok_sz[MAX_REGIONS]) >= CMPW'(req_r));

  assign tok_vld[0]   = inject_r;
  assign tok_hit[0]   = 1'b0;
  assign tok_sz[0]    = '0;
  assign tok_idx[0]   = '0;
  assign tok_first[0] = '0;

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    wfa_cell #(
      .IDX(i), .MEM_CELLS(MEM_CELLS), .MAX_REGIONS(MAX_REGIONS)
    ) u_cell (
      .clk, .rst_n, .ctl, .wr_idx, .wr_first, .wr_last,
      .used(used_r), .query_idx(query_r),
      .tok_vld_i(tok_vld[i]), .tok_hit_i(tok_hit[i]), .tok_sz_i(tok_sz[i]),
      .tok_idx_i(tok_idx[i]), .tok_first_i(tok_first[i]),
      .tok_vld_o(tok_vld[i+1]), .tok_hit_o(tok_hit[i+1]),
      .tok_sz_o(tok_sz[i+1]), .tok_idx_o(tok_idx[i+1]),
      .tok_first_o(tok_first[i+1])
    );
  end

  wfa_ram #(.WIDTH(1), .DEPTH(MEM_CELLS)) u_map (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(AW'(in_idx)), .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority case (in_tuser)
            ACT_ALLOC:     state_nxt = (used_r == '0) ? ST_DONE : ST_SCAN;
            ACT_RD_CELL:   state_nxt = cell_in_range ? ST_RDCELL : ST_DONE;
            ACT_RD_REGION: state_nxt = reg_in_range ? ST_SCAN : ST_DONE;
            default:       state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (tok_vld[MAX_REGIONS]) begin
          state_nxt = (mode_alloc_r && grant && (req_r != '0)) ? ST_MARK : ST_DONE;
        end
      end
      ST_MARK: begin
        if (mark_left_r == REQ_W'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_RDCELL: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = (state_r == ST_IDLE);
    map_len_nxt   = map_len_r;
    used_nxt      = used_r;
    prev_free_nxt = prev_free_r;
    mode_alloc_nxt = mode_alloc_r;
    inject_nxt    = 1'b0;
    req_nxt       = req_r;
    query_nxt     = query_r;
    mark_addr_nxt = mark_addr_r;
    mark_left_nxt = mark_left_r;
    ok_nxt        = ok_r;
    pos_nxt       = pos_r;
    rix_nxt       = rix_r;
    sz_nxt        = sz_r;
    cval_nxt      = cval_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_data_nxt  = out_data_r;
    ctl           = '{scan_alloc: mode_alloc_r, wr_first: 1'b0, wr_last: 1'b0};
    wr_idx        = RW'(used_r);
    wr_first      = map_len_r;
    wr_last       = AW'(map_len_r);
    ram_we        = 1'b0;
    ram_waddr     = AW'(map_len_r);
    ram_wdata     = in_bit;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ok_nxt   = 1'b0;
          pos_nxt  = '0;
          rix_nxt  = '0;
          sz_nxt   = '0;
          cval_nxt = 1'b0;
          req_nxt  = in_req;
          query_nxt = RW'(in_idx);
          priority case (in_tuser)
            ACT_CLEAR: begin
              map_len_nxt   = '0;
              used_nxt      = '0;
              prev_free_nxt = 1'b0;
              ok_nxt        = 1'b0 | 1'b1;
            end
            ACT_APPEND: begin
              if (map_len_r < LW'(MEM_CELLS)) begin
                if (!in_bit && prev_free_r && (used_r != '0)) begin
                  ctl.wr_last = 1'b1;
                  wr_idx      = RW'(used_r - CW'(1));
                  ram_we      = 1'b1;
                  map_len_nxt = map_len_r + LW'(1);
                  ok_nxt      = 1'b1;
                end else if (!in_bit) begin
                  if (used_r < CW'(MAX_REGIONS)) begin
                    ctl.wr_first  = 1'b1;
                    ctl.wr_last   = 1'b1;
                    used_nxt      = used_r + CW'(1);
                    prev_free_nxt = 1'b1;
                    ram_we        = 1'b1;
                    map_len_nxt   = map_len_r + LW'(1);
                    ok_nxt        = 1'b1;
                  end
                end else begin
                  prev_free_nxt = 1'b0;
                  ram_we        = 1'b1;
                  map_len_nxt   = map_len_r + LW'(1);
                  ok_nxt        = 1'b1;
                end
              end
            end
            ACT_ALLOC: begin
              mode_alloc_nxt = 1'b1;
              inject_nxt     = (used_r != '0);
            end
            ACT_RD_REGION: begin
              mode_alloc_nxt = 1'b0;
              inject_nxt     = reg_in_range;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (tok_vld[MAX_REGIONS]) begin
          rix_nxt = tok_idx[MAX_REGIONS];
          sz_nxt  = tok_sz[MAX_REGIONS];
          if (!mode_alloc_r) begin
            ok_nxt = 1'b1;
          end else if (grant) begin
            ok_nxt = 1'b1;
            if (req_r != '0) begin
              pos_nxt       = tok_first[MAX_REGIONS];
              ctl.wr_first  = 1'b1;
              wr_idx        = tok_idx[MAX_REGIONS];
              wr_first      = tok_first[MAX_REGIONS] + LW'(req_r);
              mark_addr_nxt = AW'(tok_first[MAX_REGIONS]);
              mark_left_nxt = req_r;
            end
          end
        end
      end
      ST_MARK: begin
        ram_we        = 1'b1;
        ram_waddr     = mark_addr_r;
        ram_wdata     = 1'b1;
        mark_addr_nxt = mark_addr_r + AW'(1);
        mark_left_nxt = mark_left_r - REQ_W'(1);
      end
      ST_RDCELL: begin
        ok_nxt   = 1'b1;
        cval_nxt = ram_rdata;
      end
      ST_DONE: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {2'b00, RCNT_W'(used_r), cval_r, SIZE_W'(sz_r),
                          RIX_W'(rix_r), POS_W'(pos_r), ok_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      map_len_r   <= '0;
      used_r      <= '0;
      prev_free_r <= 1'b0;
      inject_r    <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      map_len_r   <= map_len_nxt;
      used_r      <= used_nxt;
      prev_free_r <= prev_free_nxt;
      inject_r    <= inject_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_alloc_r <= mode_alloc_nxt;
    req_r        <= req_nxt;
    query_r      <= query_nxt;
    mark_addr_r  <= mark_addr_nxt;
    mark_left_r  <= mark_left_nxt;
    ok_r         <= ok_nxt;
    pos_r        <= pos_nxt;
    rix_r        <= rix_nxt;
    sz_r         <= sz_nxt;
    cval_r       <= cval_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
endmodule

@@ rtl/core/wfa_checker.sv @@
// Port-level checks for the worst-fit allocator, bound to the top level.
// Depends on worst_fit_allocator_assert.svh.
`include "worst_fit_allocator_assert.svh"
module wfa_checker #(
  parameter int unsigned MAX_REGIONS = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  `WFA_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "Stalled result changed")
  `WFA_ASSERT(a_one_in_flight, in_tvalid && in_tready |=> !in_tready, "Second transfer taken while busy")
  `WFA_ASSERT(a_count_bound, out_tvalid |-> out_tdata[29:23] <= 7'(MAX_REGIONS), "Region count out of range")
  `WFA_ASSERT(a_refused_clean, out_tvalid && !out_tdata[0] |-> out_tdata[7:1] == 7'd0 && !out_tdata[22], "Refused result carries data")
  `WFA_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_tvalid, "Result after reset")
endmodule

bind worst_fit_allocator wfa_checker #(.MAX_REGIONS(MAX_REGIONS)) u_wfa_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);

@@ dv/worst_fit_allocator_tb.sv @@
// Testbench for worst_fit_allocator: random and directed action streams with
// bursty idling on both channels, checked against an in-bench allocator model.
// Depends on wfa_pkg and the worst_fit_allocator RTL.
`timescale 1ns / 100ps

module worst_fit_allocator_tb;
  import wfa_pkg::*;

  localparam int unsigned CELLS   = MEM_CELLS_DEF;
  localparam int unsigned REGIONS = MAX_REGIONS_DEF;
  localparam logic [2:0] ACT_UNKNOWN_MIN = 3'd5;
  localparam logic [2:0] ACT_UNKNOWN_MAX = 3'd7;
  localparam int unsigned ITEMS = 650;
  localparam int unsigned CALM_TAIL = 60;

  typedef struct {
    logic [2:0] act;
    logic       cell_bit;
    logic [7:0] req;
    logic [6:0] idx;
  } action_t;

  typedef struct packed {
    logic [6:0] region_count;
    logic       cell_value;
    logic [7:0] size;
    logic [5:0] region_index;
    logic [6:0] position;
    logic       ok;
  } reply_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  worst_fit_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  action_t pending_actions[$];
  reply_t  expected_replies[$];
  int      mismatches;
  int      grants;
  int      refusals;
  int      checked;
  bit      calm;
  bit      taken;
  int      send_gap;
  int      recv_stall;

  // Allocator state as seen by the predictor.
  bit          map_bits[CELLS];
  int unsigned map_len;
  int unsigned region_cnt;
  int unsigned reg_first[REGIONS];
  int unsigned reg_last[REGIONS];
  bit          last_was_free;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d replies outstanding", expected_replies.size());
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned free_span(int unsigned r);
    int unsigned stop;
    stop = reg_last[r] + 1;
    return (stop >= reg_first[r]) ? stop - reg_first[r] : 0;
  endfunction

  function automatic reply_t allocate_step(action_t a);
    reply_t      rep;
    int unsigned best;
    int unsigned best_sz;
    int unsigned s;
    rep = '0;
    case (a.act)
      ACT_CLEAR: begin
        map_len = 0;
        region_cnt = 0;
        last_was_free = 1'b0;
        rep.ok = 1'b1;
      end
      ACT_APPEND: begin
        if (map_len < CELLS) begin
          rep.ok = 1'b1;
          if (!a.cell_bit) begin
            if (last_was_free && region_cnt > 0) begin
              reg_last[region_cnt - 1] = map_len;
            end else if (region_cnt >= REGIONS) begin
              rep.ok = 1'b0;
            end else begin
              reg_first[region_cnt] = map_len;
              reg_last[region_cnt] = map_len;
              region_cnt++;
            end
            if (rep.ok) last_was_free = 1'b1;
          end else begin
            last_was_free = 1'b0;
          end
          if (rep.ok) begin
            map_bits[map_len] = a.cell_bit;
            map_len++;
          end
        end
      end
      ACT_ALLOC: begin
        if (region_cnt > 0) begin
          best = 0;
          best_sz = free_span(0);
          for (int unsigned r = 1; r < region_cnt; r++) begin
            s = free_span(r);
            if (s > best_sz) begin
              best_sz = s;
              best = r;
            end
          end
          rep.region_index = best[5:0];
          rep.size = best_sz[7:0];
          if (best_sz >= a.req) begin
            rep.ok = 1'b1;
            if (a.req > 0) begin
              rep.position = reg_first[best][6:0];
              for (int unsigned j = 0; j < a.req; j++) begin
                if (reg_first[best] + j < CELLS) map_bits[reg_first[best] + j] = 1'b1;
              end
              reg_first[best] += a.req;
            end
          end
        end
      end
      ACT_RD_CELL: begin
        if (a.idx < map_len) begin
          rep.ok = 1'b1;
          rep.cell_value = map_bits[a.idx];
        end
      end
      ACT_RD_REGION: begin
        if (a.idx < region_cnt) begin
          rep.ok = 1'b1;
          rep.region_index = a.idx[5:0];
          s = free_span(a.idx);
          rep.size = s[7:0];
        end
      end
      default: ;
    endcase
    rep.region_count = region_cnt[6:0];
    return rep;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("Mismatch on reply %0d: %s got %0d, expected %0d", checked, what, got, want);
    mismatches++;
  endtask

  // Driver: new transfers are presented on the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_actions.size() > 0) begin
          action_t a;
          a = pending_actions.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= a.act;
          in_tdata <= {a.idx, a.req, a.cell_bit};
          if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 17);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) recv_stall = $urandom_range(1, 17);
      end
    end
  end

  // Monitor: both channels are sampled on the rising edge.
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    action_t a;
    taken <= in_tvalid && in_tready && rst_n;
    if (rst_n && in_tvalid && in_tready) begin
      a.act = in_tuser;
      a.cell_bit = in_tdata[0];
      a.req = in_tdata[8:1];
      a.idx = in_tdata[15:9];
      expected_replies.push_back(allocate_step(a));
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = reply_t'(out_tdata[29:0]);
      checked++;
      if (out_tdata[31:30] != 2'b00) report_mismatch("pad bits", out_tdata[31:30], 0);
      if (expected_replies.size() == 0) begin
        $display("Unexpected reply %0d", checked);
        mismatches++;
      end else begin
        want = expected_replies.pop_front();
        if (got.ok) grants++; else refusals++;
        if (got.ok != want.ok) report_mismatch("ok", got.ok, want.ok);
        if (got.position != want.position)
          report_mismatch("position", got.position, want.position);
        if (got.region_index != want.region_index)
          report_mismatch("region_index", got.region_index, want.region_index);
        if (got.size != want.size) report_mismatch("size", got.size, want.size);
        if (got.cell_value != want.cell_value)
          report_mismatch("cell_value", got.cell_value, want.cell_value);
        if (got.region_count != want.region_count)
          report_mismatch("region_count", got.region_count, want.region_count);
      end
    end
  end

  task automatic queue_action(logic [2:0] act, logic b, logic [7:0] req, logic [6:0] idx);
    action_t a;
    a.act = act;
    a.cell_bit = b;
    a.req = req;
    a.idx = idx;
    pending_actions.push_back(a);
  endtask

  task automatic queue_random_use();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      queue_action(ACT_ALLOC, 1'($urandom),
                   ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 20)),
                   7'($urandom));
    end else if (pick < 7) begin
      queue_action(ACT_RD_CELL, 1'($urandom), 8'($urandom), 7'($urandom_range(0, 127)));
    end else if (pick < 9) begin
      queue_action(ACT_RD_REGION, 1'($urandom), 8'($urandom), 7'($urandom_range(0, 70)));
    end else begin
      queue_action(3'($urandom_range(ACT_UNKNOWN_MIN, ACT_UNKNOWN_MAX)), 1'($urandom),
                   8'($urandom), 7'($urandom));
    end
  endtask

  initial begin
    int n;
    int free_bias;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = ACT_CLEAR;
    out_tready = 1'b0;
    mismatches = 0;
    grants = 0;
    refusals = 0;
    checked = 0;
    calm = 1'b0;
    taken = 1'b0;
    send_gap = 0;
    recv_stall = 0;
    map_len = 0;
    region_cnt = 0;
    last_was_free = 1'b0;

    // Empty map and region list first, then a small hand-built map.
    queue_action(ACT_RD_CELL, 1'b0, 8'd0, 7'd0);
    queue_action(ACT_RD_REGION, 1'b0, 8'd0, 7'd0);
    queue_action(ACT_ALLOC, 1'b0, 8'd1, 7'd0);
    queue_action(ACT_CLEAR, 1'b1, 8'd255, 7'd127);
    queue_action(ACT_APPEND, 1'b0, 8'd0, 7'd0);
    queue_action(ACT_APPEND, 1'b0, 8'd0, 7'd0);
    queue_action(ACT_APPEND, 1'b1, 8'd0, 7'd0);
    queue_action(ACT_APPEND, 1'b0, 8'd0, 7'd0);
    queue_action(ACT_APPEND, 1'b0, 8'd0, 7'd0);
    queue_action(ACT_APPEND, 1'b0, 8'd0, 7'd0);
    queue_action(ACT_ALLOC, 1'b0, 8'd2, 7'd0);
    queue_action(ACT_ALLOC, 1'b0, 8'd0, 7'd0);
    queue_action(ACT_ALLOC, 1'b0, 8'd255, 7'd0);
    queue_action(ACT_ALLOC, 1'b0, 8'd2, 7'd0);
    queue_action(ACT_ALLOC, 1'b0, 8'd1, 7'd0);
    queue_action(ACT_RD_REGION, 1'b0, 8'd0, 7'd1);
    queue_action(ACT_APPEND, 1'b0, 8'd0, 7'd0);
    queue_action(ACT_RD_REGION, 1'b0, 8'd0, 7'd1);
    queue_action(ACT_RD_CELL, 1'b0, 8'd0, 7'd3);
    queue_action(ACT_RD_CELL, 1'b0, 8'd0, 7'd127);
    queue_action(ACT_RD_REGION, 1'b0, 8'd0, 7'd127);
    queue_action(ACT_UNKNOWN_MIN, 1'b1, 8'd128, 7'd64);
    queue_action(ACT_UNKNOWN_MAX, 1'b0, 8'd0, 7'd0);

    // Random part: rebuild a map, then work on it with allocations, reads, further appends and unknown actions.
    while (pending_actions.size() < ITEMS) begin
      queue_action(ACT_CLEAR, 1'($urandom), 8'($urandom), 7'($urandom));
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(120, 135) : $urandom_range(1, 40);
      free_bias = $urandom_range(1, 9);
      for (int i = 0; i < n; i++) begin
        queue_action(ACT_APPEND, $urandom_range(0, 9) >= free_bias, 8'($urandom),
                     7'($urandom));
      end
      n = $urandom_range(2, 15);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_action(ACT_APPEND, 1'($urandom), 8'($urandom), 7'($urandom));
        end else begin
          queue_random_use();
        end
      end
    end
    queue_action(ACT_ALLOC, 1'b0, 8'd128, 7'd0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_actions.size() < CALM_TAIL);
    calm = 1'b1;
    wait (pending_actions.size() == 0 && expected_replies.size() == 0 && !in_tvalid);
    repeat (300) @(posedge clk);
    $display("Checked %0d replies: %0d granted or valid, %0d refused or out of range.",
             checked, grants, refusals);
    $display("Maps were rebuilt many times, up to overfull, with allocations and reads between.");
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/wfa_pkg.sv
rtl/core/wfa_ram.sv
rtl/core/wfa_cell.sv
rtl/core/worst_fit_allocator.sv
rtl/core/wfa_checker.sv
dv/worst_fit_allocator_tb.sv
